// File: hdl/indexed_list_store_top_assert.svh
// Assertion macros for the indexed list store.
`ifndef INDEXED_LIST_STORE_TOP_ASSERT_SVH
`define INDEXED_LIST_STORE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ILS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("list store check failed");
`define ILS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("list store check failed");
`else
`define ILS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ILS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/ils_pkg.sv
// Constants, codes and control types shared by the list store modules.
package ils_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;

    localparam int OPERATION_W = 3;
    localparam int INDEX_W     = 5;
    localparam int VALUE_W     = 32;
    localparam int READ_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [OPERATION_W-1:0] {
        OP_GET    = 3'd0,
        OP_PUSH   = 3'd1,
        OP_POP    = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [IDX_W-1:0]      pos_t;

    // Broadcast to every cell of the chain for one request.
    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_down;
        pos_t pos;
        pos_t rd_addr;
    } cell_ctl_t;

    // Outcome of one request, as seen by the top level.
    typedef struct packed {
        status_t status;
        logic    rd_en;
        cnt_t    count_next;
    } dec_res_t;

endpackage

// File: hdl/ils_req_if.sv
// Request channel of the list store: operation, index and value.
interface ils_req_if;
    logic                       valid;
    logic                       ready;
    logic [ils_pkg::OPERATION_W-1:0] operation;
    logic [ils_pkg::INDEX_W-1:0]     index;
    logic [ils_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output operation, output index, output value, input ready);
    modport sink   (input valid, input operation, input index, input value, output ready);
endinterface

// File: hdl/ils_rsp_if.sv
// Response channel of the list store: read value, status and count.
interface ils_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ils_pkg::READ_W-1:0]   read_value;
    logic [ils_pkg::STATUS_W-1:0] status;
    logic [ils_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output read_value, output status, output count, input ready);
    modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

// File: hdl/ils_cell.sv
// One storage cell of the list chain: holds a word, shifts to or from its neighbours.
module ils_cell (
    input  logic               clk,
    input  ils_pkg::cell_ctl_t ctl,
    input  ils_pkg::pos_t      pos_id,
    input  ils_pkg::word_t     wr_word,
    input  ils_pkg::word_t     from_left,
    input  ils_pkg::word_t     from_right,
    output ils_pkg::word_t     word,
    output ils_pkg::word_t     rd_word
);
    import ils_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        priority if (ctl.load && (pos_id == ctl.pos))
        begin
            word_next = wr_word;
        end
        else if (ctl.shift_up && (pos_id > ctl.pos))
        begin
            word_next = from_left;
        end
        else if (ctl.shift_down && (pos_id >= ctl.pos))
        begin
            word_next = from_right;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    // Drive zero unless addressed, so the top can OR the row together.
    assign rd_word = (pos_id == ctl.rd_addr) ? word_reg : '0;

endmodule

// File: hdl/ils_decode.sv
// Request decode: bounds checks, status, next count and the cell chain controls.
module ils_decode (
    input  logic [ils_pkg::OPERATION_W-1:0] operation,
    input  logic [ils_pkg::INDEX_W-1:0]     index,
    input  ils_pkg::cnt_t                   cnt,
    output ils_pkg::cell_ctl_t              ctl,
    output ils_pkg::dec_res_t               res
);
    import ils_pkg::*;

    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             empty;
    logic             idx_below;
    logic             idx_above;

    assign idx_ext   = CMP_W'(index);
    assign cnt_ext   = CMP_W'(cnt);
    assign full      = (cnt_ext == CMP_W'(DEPTH));
    assign empty     = (cnt == '0);
    assign idx_below = (idx_ext < cnt_ext);
    assign idx_above = (idx_ext > cnt_ext);

    always_comb
    begin
        ctl            = '0;
        res.status     = ST_OK;
        res.rd_en      = 1'b0;
        res.count_next = cnt;
        unique case (op_t'(operation))
            OP_GET:
            begin
                ctl.rd_addr = IDX_W'(index);
                if (idx_below)
                begin
                    res.rd_en = 1'b1;
                end
                else
                begin
                    res.status = ST_RANGE;
                end
            end
            OP_PUSH:
            begin
                if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    ctl.load       = 1'b1;
                    ctl.pos        = IDX_W'(cnt);
                    res.count_next = cnt + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                ctl.rd_addr = IDX_W'(cnt - CNT_W'(1));
                if (empty)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.rd_en      = 1'b1;
                    res.count_next = cnt - CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                // Index check before the full check.
                if (idx_above)
                begin
                    res.status = ST_RANGE;
                end
                else if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    ctl.load       = 1'b1;
                    ctl.shift_up   = 1'b1;
                    ctl.pos        = IDX_W'(index);
                    res.count_next = cnt + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                ctl.rd_addr = IDX_W'(index);
                if (idx_below)
                begin
                    res.rd_en      = 1'b1;
                    ctl.shift_down = 1'b1;
                    ctl.pos        = IDX_W'(index);
                    res.count_next = cnt - CNT_W'(1);
                end
                else
                begin
                    res.status = ST_RANGE;
                end
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
    end

endmodule

// File: hdl/indexed_list_store_top.sv
// Indexed list store: an ordered list of up to DEPTH words kept in a shifting chain of cells.
// Each request (get, push, pop, insert at index, remove at index) gives one registered
// response in the cycle after it is taken, with the value read, a status and the
// count held afterwards. Insert and remove move every later entry by one place as the request
// is taken, since each cell loads from its left or right neighbour in parallel, so a
// new request can be taken every cycle as long as responses are taken; a waiting
// response stalls requests only until it is taken. Entries hold no reset value; the
// count resets to zero and only entries below the count are ever read.
`include "indexed_list_store_top_assert.svh"

module indexed_list_store_top (
    input  logic  clk,
    input  logic  rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);
    import ils_pkg::*;

    cnt_t      cnt_reg;
    cnt_t      cnt_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    word_t     rd_word_reg;
    status_t   status_reg;
    cnt_t      count_out_reg;

    logic      fire;
    logic      push_grow;
    cell_ctl_t ctl;
    cell_ctl_t ctl_gated;
    dec_res_t  res;
    word_t     wr_word;
    word_t     rd_any;

    word_t     cell_word [DEPTH];
    word_t     cell_rd   [DEPTH];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign wr_word   = WORD_WIDTH'(req.value);

    ils_decode u_decode (
        .operation (req.operation),
        .index     (req.index),
        .cnt       (cnt_reg),
        .ctl       (ctl),
        .res       (res)
    );

    // Hold the chain unless the request is taken.
    always_comb
    begin
        ctl_gated            = ctl;
        ctl_gated.load       = ctl.load && fire;
        ctl_gated.shift_up   = ctl.shift_up && fire;
        ctl_gated.shift_down = ctl.shift_down && fire;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        word_t left_w;
        word_t right_w;
        if (g == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_word[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_word[g+1];
        end

        ils_cell u_cell (
            .clk        (clk),
            .ctl        (ctl_gated),
            .pos_id     (IDX_W'(g)),
            .wr_word    (wr_word),
            .from_left  (left_w),
            .from_right (right_w),
            .word       (cell_word[g]),
            .rd_word    (cell_rd[g])
        );
    end

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    assign cnt_next       = fire ? res.count_next : cnt_reg;
    assign out_valid_next = fire ? 1'b1 : (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_word_reg   <= res.rd_en ? rd_any : '0;
            status_reg    <= res.status;
            count_out_reg <= res.count_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = READ_W'(rd_word_reg);
    assign rsp.status     = status_reg;
    assign rsp.count      = COUNT_W'(count_out_reg);

    assign push_grow = fire && (req.operation == OP_PUSH) && (CMP_W'(cnt_reg) < CMP_W'(DEPTH));

    `ILS_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, (CMP_W'(cnt_reg) <= CMP_W'(DEPTH)))
    `ILS_ASSERT_NEXT(a_fire_rsp, clk, rst_n, fire, out_valid_reg)
    `ILS_ASSERT_NEXT(a_push_grow, clk, rst_n, push_grow, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `ILS_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid_reg && (status_reg != ST_OK), rd_word_reg == '0)

endmodule

// File: sim/indexed_list_store_top_tb.sv
// Self-checking testbench for the indexed list store: directed table, then random request mix.
`timescale 1ns / 1ps

module indexed_list_store_top_tb;
    import ils_pkg::*;

    localparam int          IDLE_PCT      = 6;
    localparam int          RANDOM_ITEMS  = 1600;
    localparam int          CALM_FIRST    = 500;
    localparam int          CALM_LAST     = 900;
    localparam int          PHASE_LEN     = 40;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int unsigned QUIET_LIMIT   = 2000;

    // Operation codes above remove are ignored by the store.
    localparam logic [OPERATION_W-1:0] OP_SPARE_MIN = 3'd5;
    localparam logic [OPERATION_W-1:0] OP_SPARE_MAX = 3'd7;

    localparam bit VAL_FIXED   = 1'b0;
    localparam bit VAL_RAND    = 1'b1;
    localparam bit CHECK_MODEL = 1'b0;
    localparam bit CHECK_TYPED = 1'b1;

    typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} phase_t;

    typedef struct {
        logic [READ_W-1:0]  read_value;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } list_rsp_t;

    typedef struct packed {
        logic [OPERATION_W-1:0] op;
        logic [INDEX_W-1:0]     idx;
        logic [VALUE_W-1:0]     value;
        logic [4:0]             reps;
        bit                     rnd_value;
        bit                     typed;
        logic [READ_W-1:0]      want_read;
        status_t                want_status;
        logic [COUNT_W-1:0]     want_count;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [16] = '{
        '{OP_GET,       5'd0,  32'h0000_0000, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_RANGE, 5'd0},
        '{OP_POP,       5'd0,  32'h0000_0000, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_EMPTY, 5'd0},
        '{OP_REMOVE,    5'd31, 32'h0000_0000, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_RANGE, 5'd0},
        '{OP_INSERT,    5'd1,  32'h1234_5678, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_RANGE, 5'd0},
        '{OP_PUSH,      5'd0,  32'hFFFF_FFFF, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_OK,    5'd1},
        '{OP_INSERT,    5'd0,  32'h0000_0000, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_OK,    5'd2},
        '{OP_GET,       5'd1,  32'h0000_0000, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'hFFFF_FFFF, ST_OK,    5'd2},
        '{OP_SPARE_MAX, 5'd31, 32'hFFFF_FFFF, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_OK,    5'd2},
        // fill up to the full depth
        '{OP_PUSH,      5'd0,  32'h0000_0000, 5'd14, VAL_RAND,  CHECK_MODEL,
          32'h0000_0000, ST_OK,    5'd0},
        '{OP_PUSH,      5'd0,  32'h5A5A_5A5A, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_FULL,  5'd16},
        '{OP_INSERT,    5'd16, 32'hA5A5_A5A5, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_FULL,  5'd16},
        // index check wins over the full check
        '{OP_INSERT,    5'd17, 32'hA5A5_A5A5, 5'd1,  VAL_FIXED, CHECK_TYPED,
          32'h0000_0000, ST_RANGE, 5'd16},
        '{OP_GET,       5'd15, 32'h0000_0000, 5'd1,  VAL_FIXED, CHECK_MODEL,
          32'h0000_0000, ST_OK,    5'd0},
        '{OP_REMOVE,    5'd0,  32'h0000_0000, 5'd1,  VAL_FIXED, CHECK_MODEL,
          32'h0000_0000, ST_OK,    5'd0},
        '{OP_INSERT,    5'd7,  32'h8000_0001, 5'd1,  VAL_FIXED, CHECK_MODEL,
          32'h0000_0000, ST_OK,    5'd0},
        '{OP_POP,       5'd0,  32'h0000_0000, 5'd1,  VAL_FIXED, CHECK_MODEL,
          32'h0000_0000, ST_OK,    5'd0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic calm_stretch;

    ils_req_if req_ch();
    ils_rsp_if rsp_ch();

    indexed_list_store_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the list, updated as each request is taken.
    word_t       list_words [DEPTH];
    int          list_len;
    list_rsp_t   awaited_rsps [$];

    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned ignored_sent;
    int unsigned rsps_checked;
    int unsigned status_tally [4];
    int unsigned quiet_cycles;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic list_rsp_t list_update(input logic [OPERATION_W-1:0] op,
                                              input logic [INDEX_W-1:0] idx,
                                              input logic [VALUE_W-1:0] word);
        list_rsp_t rsp;
        int        pos;
        pos            = int'(idx);
        rsp.read_value = '0;
        rsp.status     = ST_OK;
        case (op)
            OP_GET:
            begin
                if (pos >= list_len)
                    rsp.status = ST_RANGE;
                else
                    rsp.read_value = list_words[pos];
            end
            OP_PUSH:
            begin
                if (list_len >= DEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    list_words[list_len] = word_t'(word);
                    list_len++;
                end
            end
            OP_POP:
            begin
                if (list_len == 0)
                    rsp.status = ST_EMPTY;
                else
                begin
                    list_len--;
                    rsp.read_value = list_words[list_len];
                end
            end
            OP_INSERT:
            begin
                if (pos > list_len)
                    rsp.status = ST_RANGE;
                else if (list_len >= DEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = word_t'(word);
                    list_len++;
                end
            end
            OP_REMOVE:
            begin
                if (pos >= list_len)
                    rsp.status = ST_RANGE;
                else
                begin
                    rsp.read_value = list_words[pos];
                    for (int i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            default:
            begin
            end
        endcase
        rsp.count = COUNT_W'(list_len);
        return rsp;
    endfunction

    // Hold the request until the store takes it, then predict its response.
    task automatic send_request(input logic [OPERATION_W-1:0] op,
                                input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] word,
                                output list_rsp_t predicted);
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.index     <= idx;
        req_ch.value     <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = list_update(op, idx, word);
        if (op > OP_REMOVE)
            ignored_sent++;
        else
        begin
            requests_sent++;
            status_tally[predicted.status]++;
        end
    endtask

    always @(posedge clk)
        rsp_ch.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        list_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsps_checked++;
            if (awaited_rsps.size() == 0)
                flag_error($sformatf("response with none expected: value %h status %0d count %0d",
                                     rsp_ch.read_value, rsp_ch.status, rsp_ch.count));
            else
            begin
                want = awaited_rsps.pop_front();
                if (rsp_ch.read_value !== want.read_value)
                    flag_error($sformatf("read_value %h, expected %h",
                                         rsp_ch.read_value, want.read_value));
                if (rsp_ch.status !== want.status)
                    flag_error($sformatf("status %0d, expected %0d",
                                         rsp_ch.status, want.status));
                if (rsp_ch.count !== want.count)
                    flag_error($sformatf("count %0d, expected %0d",
                                         rsp_ch.count, want.count));
            end
        end
    end

    // End the run once nothing has moved on either channel for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no request or response taken for %0d cycles", QUIET_LIMIT);
            $display("indexed_list_store_top_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        list_rsp_t               predicted;
        dir_row_t                row;
        logic [OPERATION_W-1:0]  op;
        logic [INDEX_W-1:0]      idx;
        logic [VALUE_W-1:0]      word;
        phase_t                  phase;
        int                      phase_until;
        int                      grow_pct;
        int                      roll;
        int                      sent;

        rst_n            = 1'b0;
        calm_stretch     = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = '0;
        req_ch.index     = '0;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        list_len         = 0;
        quiet_cycles     = 0;
        for (int i = 0; i < DEPTH; i++)
            list_words[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
        begin
            row = DIRECTED_ROWS[r];
            for (int k = 0; k < int'(row.reps); k++)
            begin
                word = row.rnd_value ? VALUE_W'($urandom) : row.value;
                send_request(row.op, row.idx, word, predicted);
                if (row.typed)
                    awaited_rsps.push_back('{row.want_read, row.want_status, row.want_count});
                else
                    awaited_rsps.push_back(predicted);
            end
        end

        // Pick growing, shrinking or mixed phases at random so full and empty are reached often.
        sent        = 0;
        phase       = PHASE_MIXED;
        phase_until = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= phase_until)
            begin
                phase       = phase_t'($urandom_range(2));
                phase_until = sent + PHASE_LEN;
            end
            calm_stretch <= (sent >= CALM_FIRST && sent < CALM_LAST);
            grow_pct = (phase == PHASE_GROW) ? 70 : (phase == PHASE_SHRINK) ? 20 : 45;
            roll     = $urandom_range(99);
            if ($urandom_range(99) < 3)
                op = OPERATION_W'($urandom_range(OP_SPARE_MAX, OP_SPARE_MIN));
            else if (roll < grow_pct)
                op = $urandom_range(1) ? OP_PUSH : OP_INSERT;
            else if (roll < grow_pct + 15)
                op = OP_GET;
            else
                op = $urandom_range(1) ? OP_POP : OP_REMOVE;

            if ($urandom_range(99) < 15)
                idx = INDEX_W'($urandom);
            else if (op == OP_INSERT)
                idx = INDEX_W'($urandom_range(list_len));
            else if (list_len == 0)
                idx = '0;
            else
                idx = INDEX_W'($urandom_range(list_len - 1));

            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                default: word = VALUE_W'($urandom);
            endcase

            send_request(op, idx, word, predicted);
            awaited_rsps.push_back(predicted);
            if (op <= OP_REMOVE)
                sent++;
        end
        req_ch.valid <= 1'b0;

        while (awaited_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d list requests and %0d ignored codes; %0d responses checked.",
                 requests_sent, ignored_sent, rsps_checked);
        $display("Outcomes seen: ok %0d, out of range %0d, empty %0d, full %0d.",
                 status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_EMPTY],
                 status_tally[ST_FULL]);
        if (error_count == 0)
            $display("indexed_list_store_top_tb passed");
        else
            $display("indexed_list_store_top_tb failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/ils_pkg.sv
hdl/ils_req_if.sv
hdl/ils_rsp_if.sv
hdl/ils_cell.sv
hdl/ils_decode.sv
hdl/indexed_list_store_top.sv
sim/indexed_list_store_top_tb.sv
